/* rtl/npid_pkg.sv */
// Shared types and constants of the nested prefix integer decoder.
// Used by every module of the block; depends on nothing else.
package npid_pkg;

  // Input op codes.
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_EOS   = 2'd1;
  localparam logic [1:0] OP_RDERR = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EOS   = 2'd2;
  localparam logic [1:0] STAT_RDERR = 2'd3;

  // Largest final payload length that fits a 31-bit value.
  localparam logic [4:0] LIMIT_CAP = 5'd30;

  // Configuration space: one 32-bit register per word.
  localparam int unsigned REG_ADDR_W      = 3;
  localparam logic        REG_MAX_PAYLOAD = 1'b0;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_EOS,
    CMD_RDERR
  } cmd_e;

  typedef enum logic [3:0] {
    ST_TOP,
    ST_PRE15,
    ST_PRE3,
    ST_PRE1,
    ST_PRE1B,
    ST_PRE1C,
    ST_LEN3,
    ST_LEN15,
    ST_FINAL
  } stage_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [30:0] value;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
  } q_item_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

/* rtl/nested_prefix_integer_decoder_top.sv */
// Top level of the nested prefix integer decoder: front end, queue, back end
// and the configuration register. Depends on npid_pkg, npid_front, npid_fifo, npid_back.
//
// The decoder reads stream bytes most significant bit first and emits every
// integer of the four-level nested length-prefix code once the bit that
// completes it has been read. The back end walks a data byte one bit per
// cycle through the decode sequencer, unless a finished result is held up by
// a stalled output, and that sequencer sets the sustained rate. An
// end-of-stream or read-error command gives a single result with status
// two or three, after which the decoder restarts at a fresh number. Op three
// is accepted and dropped. A two-entry command queue sits between the input
// side and the sequencer, so new transfers are taken while a byte is still
// being decoded, and a holding slot plus an output register let the sequencer
// keep going while a finished result waits on a stalled output. The last
// flag of a result is known only once the rest of its byte has been scanned,
// so a result leaves the holding slot either when the next result of the
// same byte arrives or when the byte ends; the first result of a command
// therefore passes through the holding slot and then the output register
// before it appears. Results leave at most one per cycle. The max_payload_bits
// register sits at byte address 0 of the APB-style port, resets to 30 and is
// capped at 30 in use; it is to be written only while the decoder is idle.
module nested_prefix_integer_decoder_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  npid_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output npid_pkg::out_item_t                   out_data_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [npid_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  npid_pkg::q_item_t q_item;
  npid_pkg::q_head_t q_head;

  logic [4:0] max_payload_q;
  logic       reg_idx;
  logic       reg_wr;

  // Registers are word aligned; the word index picks the register and the
  // byte offset within a word is not decoded.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= npid_pkg::LIMIT_CAP;
    end else if (reg_wr && (reg_idx == npid_pkg::REG_MAX_PAYLOAD)) begin
      max_payload_q <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if ((reg_idx == npid_pkg::REG_MAX_PAYLOAD) && (paddr[1:0] == 2'b00)) begin
      prdata = {27'b0, max_payload_q};
    end else if (reg_idx == npid_pkg::REG_MAX_PAYLOAD) begin
      // Unaligned reads return the same word.
      prdata = {27'b0, max_payload_q};
    end
  end

  // The front end classifies each transfer and pushes it into the queue.
  npid_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  npid_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  // The back end walks each byte bit by bit and produces the results.
  npid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_payload_i (max_payload_q),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

/* rtl/npid_front.sv */
// Front end: accepts input transfers and classifies them into queue commands.
// Depends on npid_pkg.
module npid_front (
  input  npid_pkg::in_item_t in_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output npid_pkg::q_item_t  q_item_o
);

  logic    is_cmd;
  npid_pkg::cmd_e cmd;

  // Op three carries no work; it is accepted and dropped here.
  always_comb begin
    is_cmd = 1'b1;
    cmd    = npid_pkg::CMD_DATA;
    case (in_data_i.op)
      npid_pkg::OP_DATA:  cmd = npid_pkg::CMD_DATA;
      npid_pkg::OP_EOS:   cmd = npid_pkg::CMD_EOS;
      npid_pkg::OP_RDERR: cmd = npid_pkg::CMD_RDERR;
      default:            is_cmd = 1'b0;
    endcase
  end

  assign in_stall_o         = q_full_i;
  assign q_push_o           = in_valid_i && !q_full_i && is_cmd;
  assign q_item_o.cmd       = cmd;
  assign q_item_o.data_byte = in_data_i.data_byte;

endmodule

/* rtl/npid_fifo.sv */
// Short command queue that decouples the front end from the bit sequencer.
// Depends on npid_pkg.
module npid_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  npid_pkg::q_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output npid_pkg::q_head_t head_o
);

  npid_pkg::q_item_t mem_q [npid_pkg::QUEUE_DEPTH];
  logic [npid_pkg::QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [npid_pkg::QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [npid_pkg::QUEUE_AW:0]   count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == (npid_pkg::QUEUE_AW+1)'(npid_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == npid_pkg::QUEUE_AW'(npid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == npid_pkg::QUEUE_AW'(npid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/npid_back.sv */
// Back end: bit-serial decode sequencer, one-result holding slot and output register.
// Depends on npid_pkg.
module npid_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          max_payload_i,
  input  npid_pkg::q_head_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output npid_pkg::out_item_t out_data_o
);

  // Current command.
  logic           cur_valid_q;
  npid_pkg::cmd_e cur_cmd_q;
  logic [7:0]     shift_q;
  logic [2:0]     cnt_q;

  // Decoder state.
  npid_pkg::stage_e stage_q, stage_d;
  logic [4:0]       rem_q, rem_d;
  logic [30:0]      acc_q, acc_d;

  // Holding slot: the newest result, whose last flag is not yet known until closed.
  logic        pend_valid_q, pend_valid_d;
  logic        pend_closed_q, pend_closed_d;
  logic [30:0] pend_value_q;
  logic [1:0]  pend_status_q;

  logic                out_valid_q;
  npid_pkg::out_item_t out_data_q;

  logic        bit_w;
  logic        final_w;
  logic [30:0] acc_sh;
  logic [4:0]  rem_m;
  logic [4:0]  limit;
  logic        res_valid;
  logic [30:0] res_value;
  logic [1:0]  res_status;
  logic        start_fin;
  logic [15:0] fin_len;
  logic        do_clear;
  logic        res_fire, out_free, move, step, load;

  assign bit_w   = shift_q[7];
  assign final_w = (cur_cmd_q != npid_pkg::CMD_DATA) || (cnt_q == 3'd7);
  assign acc_sh  = {acc_q[29:0], bit_w};
  assign rem_m   = rem_q - 5'd1;
  assign limit   = (max_payload_i > npid_pkg::LIMIT_CAP) ? npid_pkg::LIMIT_CAP : max_payload_i;

  // One decode step on the current bit (or on an end-of-stream/read-error command).
  always_comb begin
    stage_d    = stage_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = npid_pkg::STAT_OK;
    start_fin  = 1'b0;
    fin_len    = '0;
    do_clear   = 1'b0;
    if (cur_cmd_q != npid_pkg::CMD_DATA) begin
      res_valid  = 1'b1;
      res_status = (cur_cmd_q == npid_pkg::CMD_EOS) ? npid_pkg::STAT_EOS : npid_pkg::STAT_RDERR;
      do_clear   = 1'b1;
    end else begin
      case (stage_q)
        npid_pkg::ST_PRE15: begin
          if (!bit_w) begin
            start_fin = 1'b1;
            fin_len   = 16'd1;
          end else begin
            stage_d = npid_pkg::ST_PRE3;
          end
        end
        npid_pkg::ST_PRE3: begin
          if (!bit_w) begin
            acc_d   = 31'd1;
            rem_d   = 5'd1;
            stage_d = npid_pkg::ST_LEN15;
          end else begin
            stage_d = npid_pkg::ST_PRE1;
          end
        end
        npid_pkg::ST_PRE1: begin
          if (!bit_w) begin
            acc_d   = 31'd1;
            rem_d   = 5'd1;
            stage_d = npid_pkg::ST_LEN3;
          end else begin
            stage_d = npid_pkg::ST_PRE1B;
          end
        end
        npid_pkg::ST_PRE1B: begin
          if (bit_w) begin
            res_valid  = 1'b1;
            res_status = npid_pkg::STAT_RANGE;
            do_clear   = 1'b1;
          end else begin
            stage_d = npid_pkg::ST_PRE1C;
          end
        end
        npid_pkg::ST_PRE1C: begin
          acc_d   = 31'd1;
          rem_d   = {3'b000, 1'b1, bit_w};
          stage_d = npid_pkg::ST_LEN3;
        end
        npid_pkg::ST_LEN3, npid_pkg::ST_LEN15, npid_pkg::ST_FINAL: begin
          acc_d = acc_sh;
          rem_d = rem_m;
          if (rem_m == '0) begin
            if (stage_q == npid_pkg::ST_LEN3) begin
              rem_d   = acc_sh[4:0];
              acc_d   = 31'd1;
              stage_d = npid_pkg::ST_LEN15;
            end else if (stage_q == npid_pkg::ST_LEN15) begin
              start_fin = 1'b1;
              fin_len   = acc_sh[15:0];
            end else begin
              res_valid = 1'b1;
              res_value = acc_sh;
              do_clear  = 1'b1;
            end
          end
        end
        default: begin
          if (!bit_w) begin
            res_valid = 1'b1;
            res_value = 31'd1;
          end else begin
            stage_d = npid_pkg::ST_PRE15;
          end
        end
      endcase
    end
    if (start_fin) begin
      if (fin_len > {11'b0, limit}) begin
        res_valid  = 1'b1;
        res_status = npid_pkg::STAT_RANGE;
        do_clear   = 1'b1;
      end else begin
        acc_d   = 31'd1;
        rem_d   = fin_len[4:0];
        stage_d = npid_pkg::ST_FINAL;
      end
    end
    if (do_clear) begin
      stage_d = npid_pkg::ST_TOP;
      rem_d   = '0;
      acc_d   = '0;
    end
  end

  // A new result needs the slot emptied first; a closed slot drains on its own.
  assign res_fire = cur_valid_q && res_valid;
  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = pend_valid_q && out_free && (pend_closed_q || res_fire);
  assign step     = cur_valid_q && (!res_valid || !pend_valid_q || out_free);
  assign load     = head_i.valid && (!cur_valid_q || (step && final_w));
  assign pop_o    = load;

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_closed_d = pend_closed_q;
    if (step && res_valid) begin
      pend_valid_d  = 1'b1;
      pend_closed_d = final_w;
    end else begin
      if (move) begin
        pend_valid_d = 1'b0;
      end
      if (step && final_w) begin
        pend_closed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q   <= 1'b0;
      cur_cmd_q     <= npid_pkg::CMD_DATA;
      cnt_q         <= '0;
      stage_q       <= npid_pkg::ST_TOP;
      rem_q         <= '0;
      acc_q         <= '0;
      pend_valid_q  <= 1'b0;
      pend_closed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        cur_cmd_q   <= head_i.item.cmd;
        cnt_q       <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + 3'd1;
        if (final_w) begin
          cur_valid_q <= 1'b0;
        end
      end
      if (step) begin
        stage_q <= stage_d;
        rem_q   <= rem_d;
        acc_q   <= acc_d;
      end
      pend_valid_q  <= pend_valid_d;
      pend_closed_q <= pend_closed_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= head_i.item.data_byte;
    end else if (step) begin
      shift_q <= {shift_q[6:0], 1'b0};
    end
    if (step && res_valid) begin
      pend_value_q  <= res_value;
      pend_status_q <= res_status;
    end
    if (move) begin
      out_data_q.value  <= pend_value_q;
      out_data_q.status <= pend_status_q;
      out_data_q.last   <= pend_closed_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
